// ===== hdl/kli_pkg.sv =====
// shared constants, command and status types for the keyframe interpolator
// no dependencies
package kli_pkg;

   localparam int VALUE_W       = 32;
   localparam int LANES         = 4;
   localparam int MAX_KEYFRAMES = 64;
   localparam int KEY_IDX_W     = $clog2(MAX_KEYFRAMES);
   localparam int STEPS_W       = 12;
   localparam int FRAMES_W      = 7;
   localparam int CSR_DATA_W    = 12;
   localparam int CSR_IDX_W     = 1;
   localparam int LANE_W        = $clog2(LANES);
   localparam int DIV_CNT_W     = $clog2(VALUE_W);

   localparam logic [STEPS_W-1:0]  STEPS_RESET  = STEPS_W'(70);
   localparam logic [FRAMES_W-1:0] FRAMES_RESET = FRAMES_W'(33);
   localparam logic [STEPS_W-1:0]  STEP_RESET   = STEPS_W'(33);
   localparam logic [FRAMES_W-1:0] FRAMES_MAX   = FRAMES_W'(MAX_KEYFRAMES);

   localparam logic [CSR_IDX_W-1:0] CSR_STEPS  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAMES = 1'b1;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   typedef logic [LANES-1:0][VALUE_W-1:0] key_row_type;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_RDA   = 7'b0000010,
      S_RDB   = 7'b0000100,
      S_DLOAD = 7'b0001000,
      S_DIV   = 7'b0010000,
      S_ADD   = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   typedef struct packed {
      logic                 mem_we;
      logic                 rd_en;
      logic [KEY_IDX_W-1:0] rd_addr;
      logic                 cap_a;
      logic                 load_pos;
      logic                 div_start;
      logic [LANE_W-1:0]    lane;
      logic                 inc_we;
      logic                 add_en;
      logic                 out_load;
      logic                 out_playing;
      logic [KEY_IDX_W-1:0] out_segment;
      logic [STEPS_W-1:0]   steps;
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } status_type;

endpackage

// ===== hdl/kli_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle, signed result saturated
// depends on kli_pkg
module kli_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          dividend_neg,
   input  logic [kli_pkg::VALUE_W-1:0]   dividend_mag,
   input  logic [kli_pkg::STEPS_W-1:0]   divisor,
   output logic                          done,
   output logic [kli_pkg::VALUE_W-1:0]   quotient
);
   import kli_pkg::*;

   logic                  run_ff, run_in;
   logic                  done_ff, done_in;
   logic [DIV_CNT_W-1:0]  count_ff, count_in;
   logic [STEPS_W-1:0]    rem_ff, rem_in;
   logic [VALUE_W-1:0]    q_ff, q_in;
   logic [STEPS_W-1:0]    div_ff, div_in;
   logic                  neg_ff, neg_in;
   logic [STEPS_W:0]      rem_shift;
   logic [STEPS_W:0]      rem_sub;

   localparam logic [VALUE_W-1:0] MIN_MAG = {1'b1, {(VALUE_W-1){1'b0}}};
   localparam logic [VALUE_W-1:0] MAX_POS = {1'b0, {(VALUE_W-1){1'b1}}};

   always_comb begin
      rem_shift = {rem_ff, q_ff[VALUE_W-1]};
      rem_sub   = rem_shift - {1'b0, div_ff};
      run_in    = run_ff;
      done_in   = 1'b0;
      count_in  = count_ff;
      rem_in    = rem_ff;
      q_in      = q_ff;
      div_in    = div_ff;
      neg_in    = neg_ff;
      if (start) begin
         run_in   = 1'b1;
         count_in = '0;
         rem_in   = '0;
         q_in     = dividend_mag;
         div_in   = divisor;
         neg_in   = dividend_neg;
      end else if (run_ff) begin
         if (rem_shift >= {1'b0, div_ff}) begin
            rem_in = rem_sub[STEPS_W-1:0];
            q_in   = {q_ff[VALUE_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[STEPS_W-1:0];
            q_in   = {q_ff[VALUE_W-2:0], 1'b0};
         end
         count_in = count_ff + 1'b1;
         if (count_ff == DIV_CNT_W'(VALUE_W-1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      rem_ff   <= rem_in;
      q_ff     <= q_in;
      div_ff   <= div_in;
      neg_ff   <= neg_in;
   end

   always_comb begin
      if (!neg_ff) begin
         quotient = q_ff[VALUE_W-1] ? MAX_POS : q_ff;
      end else if (q_ff > MIN_MAG) begin
         quotient = MIN_MAG;
      end else begin
         quotient = (~q_ff) + 1'b1;
      end
   end

   assign done = done_ff;

endmodule

// ===== hdl/kli_datapath.sv =====
// keyframe memory, pose and increment registers, result payload registers
// depends on kli_pkg and kli_div
module kli_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [kli_pkg::KEY_IDX_W-1:0]   req_key_index,
   input  logic [kli_pkg::VALUE_W-1:0]     req_key_x,
   input  logic [kli_pkg::VALUE_W-1:0]     req_key_y,
   input  logic [kli_pkg::VALUE_W-1:0]     req_key_z,
   input  logic [kli_pkg::VALUE_W-1:0]     req_key_angle,
   input  kli_pkg::cmd_type                cmd,
   output kli_pkg::status_type             status,
   output logic [kli_pkg::VALUE_W-1:0]     rsp_pos_x,
   output logic [kli_pkg::VALUE_W-1:0]     rsp_pos_y,
   output logic [kli_pkg::VALUE_W-1:0]     rsp_pos_z,
   output logic [kli_pkg::VALUE_W-1:0]     rsp_angle,
   output logic                            rsp_playing,
   output logic [kli_pkg::KEY_IDX_W-1:0]   rsp_segment
);
   import kli_pkg::*;

   key_row_type             key_mem [MAX_KEYFRAMES];
   logic [MAX_KEYFRAMES-1:0] key_valid_ff;
   key_row_type             rd_ff;
   logic                    rd_valid_ff;
   key_row_type             rd_key;
   key_row_type             key_a_ff;
   key_row_type             pos_ff, pos_in;
   key_row_type             inc_ff, inc_in;
   key_row_type             out_pos_ff;
   logic                    out_playing_ff;
   logic [KEY_IDX_W-1:0]    out_segment_ff;
   logic [VALUE_W:0]        diff;
   logic [VALUE_W-1:0]      diff_mag;
   logic                    div_done;
   logic [VALUE_W-1:0]      div_quot;

   function automatic logic [VALUE_W-1:0] sat_add(input logic [VALUE_W-1:0] a,
                                                  input logic [VALUE_W-1:0] b);
      logic [VALUE_W:0] s;
      s = {a[VALUE_W-1], a} + {b[VALUE_W-1], b};
      if (s[VALUE_W] != s[VALUE_W-1]) begin
         sat_add = s[VALUE_W] ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
      end else begin
         sat_add = s[VALUE_W-1:0];
      end
   endfunction

   // keyframe store, cleared at reset through the valid bits
   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         key_mem[req_key_index] <= {req_key_angle, req_key_z, req_key_y, req_key_x};
      end
      if (cmd.rd_en) begin
         rd_ff       <= key_mem[cmd.rd_addr];
         rd_valid_ff <= key_valid_ff[cmd.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_valid_ff <= '0;
      end else if (cmd.mem_we) begin
         key_valid_ff[req_key_index] <= 1'b1;
      end
   end

   assign rd_key = rd_valid_ff ? rd_ff : '0;

   always_comb begin
      diff     = {rd_key[cmd.lane][VALUE_W-1], rd_key[cmd.lane]}
               - {key_a_ff[cmd.lane][VALUE_W-1], key_a_ff[cmd.lane]};
      diff_mag = diff[VALUE_W] ? VALUE_W'((~diff) + 1'b1) : diff[VALUE_W-1:0];
   end

   kli_div u_div (
      .clock        (clock),
      .reset        (reset),
      .start        (cmd.div_start),
      .dividend_neg (diff[VALUE_W]),
      .dividend_mag (diff_mag),
      .divisor      (cmd.steps),
      .done         (div_done),
      .quotient     (div_quot)
   );

   assign status.div_done = div_done;

   always_comb begin
      pos_in = pos_ff;
      inc_in = inc_ff;
      if (cmd.load_pos) begin
         pos_in = rd_key;
      end
      if (cmd.add_en) begin
         for (int k = 0; k < LANES; k++) begin
            pos_in[k] = sat_add(pos_ff[k], inc_ff[k]);
         end
      end
      if (cmd.inc_we) begin
         inc_in[cmd.lane] = div_quot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         inc_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         inc_ff <= inc_in;
      end
      if (cmd.cap_a) begin
         key_a_ff <= rd_key;
      end
      if (cmd.out_load) begin
         out_pos_ff     <= pos_ff;
         out_playing_ff <= cmd.out_playing;
         out_segment_ff <= cmd.out_segment;
      end
   end

   assign rsp_pos_x   = out_pos_ff[0];
   assign rsp_pos_y   = out_pos_ff[1];
   assign rsp_pos_z   = out_pos_ff[2];
   assign rsp_angle   = out_pos_ff[3];
   assign rsp_playing = out_playing_ff;
   assign rsp_segment = out_segment_ff;

endmodule

// ===== hdl/kli_ctrl.sv =====
// playback controller: handshakes, config registers, play state and sequencing
// depends on kli_pkg
module kli_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_operation,
   input  logic                              req_start_pressed,
   input  logic                              req_rearm_pressed,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic                              csr_write,
   input  logic [kli_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [kli_pkg::CSR_DATA_W-1:0]    csr_data,
   output kli_pkg::cmd_type                  cmd,
   input  kli_pkg::status_type               status
);
   import kli_pkg::*;

   state_type               state_ff, state_in;
   logic [STEPS_W-1:0]      steps_reg_ff;
   logic [FRAMES_W-1:0]     frames_reg_ff;
   logic                    play_ff, play_in;
   logic                    latch_ff, latch_in;
   logic [KEY_IDX_W-1:0]    seg_ff, seg_in;
   logic [STEPS_W-1:0]      step_ff, step_in;
   logic                    begin_ff, begin_in;
   logic [LANE_W-1:0]       lane_ff, lane_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STEPS_W-1:0]      steps_eff;
   logic [FRAMES_W-1:0]     frames_eff;
   logic                    accept;
   logic                    out_free;
   logic                    start_eff;
   logic                    begin_play;
   logic [KEY_IDX_W-1:0]    seg_next;

   assign steps_eff  = (steps_reg_ff == '0) ? STEPS_W'(1) : steps_reg_ff;
   assign frames_eff = (frames_reg_ff > FRAMES_MAX) ? FRAMES_MAX : frames_reg_ff;
   assign req_stall  = (state_ff != S_IDLE);
   assign accept     = req_valid && (state_ff == S_IDLE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign start_eff  = req_start_pressed && !latch_ff;
   assign begin_play = start_eff && !play_ff && (frames_eff > FRAMES_W'(1));
   assign seg_next   = seg_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_reg_ff  <= STEPS_RESET;
         frames_reg_ff <= FRAMES_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_STEPS:  steps_reg_ff  <= csr_data[STEPS_W-1:0];
            CSR_FRAMES: frames_reg_ff <= csr_data[FRAMES_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      play_in      = play_ff;
      latch_in     = latch_ff;
      seg_in       = seg_ff;
      step_in      = step_ff;
      begin_in     = begin_ff;
      lane_in      = lane_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      cmd.steps       = steps_eff;
      cmd.lane        = lane_ff;
      cmd.out_playing = play_ff;
      cmd.out_segment = seg_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_operation == OP_WRITE) begin
                  cmd.mem_we = 1'b1;
                  state_in   = S_DONE;
               end else if (begin_play) begin
                  // load keyframe 0, divide segment 0, then take the first step
                  play_in  = 1'b1;
                  latch_in = !req_rearm_pressed;
                  seg_in   = '0;
                  step_in  = STEPS_W'(1);
                  begin_in = 1'b1;
                  state_in = S_RDA;
               end else begin
                  if (req_rearm_pressed) begin
                     latch_in = 1'b0;
                  end
                  if (start_eff) begin
                     play_in  = 1'b0;
                     state_in = S_DONE;
                  end else if (!play_ff) begin
                     state_in = S_DONE;
                  end else if (step_ff >= steps_eff) begin
                     if ({2'b00, seg_next} + 8'd2 > {1'b0, frames_eff}) begin
                        seg_in   = '0;
                        play_in  = 1'b0;
                        state_in = S_DONE;
                     end else begin
                        seg_in   = seg_next;
                        step_in  = '0;
                        begin_in = 1'b0;
                        state_in = S_RDA;
                     end
                  end else begin
                     step_in  = step_ff + 1'b1;
                     state_in = S_ADD;
                  end
               end
            end
         end
         S_RDA: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = seg_ff;
            state_in    = S_RDB;
         end
         S_RDB: begin
            cmd.rd_en    = 1'b1;
            cmd.rd_addr  = seg_next;
            cmd.cap_a    = 1'b1;
            cmd.load_pos = begin_ff;
            lane_in      = '0;
            state_in     = S_DLOAD;
         end
         S_DLOAD: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (status.div_done) begin
               cmd.inc_we = 1'b1;
               if (lane_ff == LANE_W'(LANES-1)) begin
                  state_in = begin_ff ? S_ADD : S_DONE;
               end else begin
                  lane_in  = lane_ff + 1'b1;
                  state_in = S_DLOAD;
               end
            end
         end
         S_ADD: begin
            cmd.add_en = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         play_ff      <= 1'b0;
         latch_ff     <= 1'b0;
         seg_ff       <= '0;
         step_ff      <= STEP_RESET;
         begin_ff     <= 1'b0;
         lane_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         play_ff      <= play_in;
         latch_ff     <= latch_in;
         seg_ff       <= seg_in;
         step_ff      <= step_in;
         begin_ff     <= begin_in;
         lane_ff      <= lane_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef NO_ASSERTIONS
   // a new result only appears when the sequencer finishes an item
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result raised outside the finishing state");

   // an accepted item always leaves the idle state
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != S_IDLE))
      else $error("accepted item not taken up by the sequencer");

   // divider completion is only seen while waiting for it
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> (state_ff == S_DIV))
      else $error("divider finished outside the division state");

   // a pending result is not overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !cmd.out_load)
      else $error("stalled result overwritten");
`endif

endmodule

// ===== hdl/keyframe_linear_interpolator_core.sv =====
// keyframe player: a write item or a tick that does not step goes straight to the finishing
// state, a stepping tick passes the add state first; a segment start reads two keyframes and
// runs four divisions on one bit-serial divider, one lane after another, and a start press
// also takes the first step; one item is in work at a time
// and a finished result waits in the output register, a stalled one holds the next item
// reset (synchronous, active high) restores register defaults, pose, increments, play state
module keyframe_linear_interpolator_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_operation,
   input  logic [kli_pkg::KEY_IDX_W-1:0]     req_key_index,
   input  logic [kli_pkg::VALUE_W-1:0]       req_key_x,
   input  logic [kli_pkg::VALUE_W-1:0]       req_key_y,
   input  logic [kli_pkg::VALUE_W-1:0]       req_key_z,
   input  logic [kli_pkg::VALUE_W-1:0]       req_key_angle,
   input  logic                              req_start_pressed,
   input  logic                              req_rearm_pressed,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [kli_pkg::VALUE_W-1:0]       rsp_pos_x,
   output logic [kli_pkg::VALUE_W-1:0]       rsp_pos_y,
   output logic [kli_pkg::VALUE_W-1:0]       rsp_pos_z,
   output logic [kli_pkg::VALUE_W-1:0]       rsp_angle,
   output logic                              rsp_playing,
   output logic [kli_pkg::KEY_IDX_W-1:0]     rsp_segment,
   input  logic                              csr_write,
   input  logic [kli_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [kli_pkg::CSR_DATA_W-1:0]    csr_data
);
   import kli_pkg::*;

   cmd_type    cmd;
   status_type status;

   kli_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_start_pressed (req_start_pressed),
      .req_rearm_pressed (req_rearm_pressed),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .cmd               (cmd),
      .status            (status)
   );

   kli_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_key_index (req_key_index),
      .req_key_x     (req_key_x),
      .req_key_y     (req_key_y),
      .req_key_z     (req_key_z),
      .req_key_angle (req_key_angle),
      .cmd           (cmd),
      .status        (status),
      .rsp_pos_x     (rsp_pos_x),
      .rsp_pos_y     (rsp_pos_y),
      .rsp_pos_z     (rsp_pos_z),
      .rsp_angle     (rsp_angle),
      .rsp_playing   (rsp_playing),
      .rsp_segment   (rsp_segment)
   );

endmodule

// ===== dv/kli_checker.sv =====
// result checker for keyframe_linear_interpolator_core: watches the request, result and
// register ports, predicts the pose after every accepted item and compares field by field
// depends on kli_pkg
module kli_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic                              req_operation,
   input  logic [kli_pkg::KEY_IDX_W-1:0]     req_key_index,
   input  logic [kli_pkg::VALUE_W-1:0]       req_key_x,
   input  logic [kli_pkg::VALUE_W-1:0]       req_key_y,
   input  logic [kli_pkg::VALUE_W-1:0]       req_key_z,
   input  logic [kli_pkg::VALUE_W-1:0]       req_key_angle,
   input  logic                              req_start_pressed,
   input  logic                              req_rearm_pressed,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [kli_pkg::VALUE_W-1:0]       rsp_pos_x,
   input  logic [kli_pkg::VALUE_W-1:0]       rsp_pos_y,
   input  logic [kli_pkg::VALUE_W-1:0]       rsp_pos_z,
   input  logic [kli_pkg::VALUE_W-1:0]       rsp_angle,
   input  logic                              rsp_playing,
   input  logic [kli_pkg::KEY_IDX_W-1:0]     rsp_segment,
   input  logic                              csr_write,
   input  logic [kli_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [kli_pkg::CSR_DATA_W-1:0]    csr_data,
   output int                                fail_count,
   output int                                pending,
   output int                                checked_count
);
   import kli_pkg::*;

   typedef struct packed {
      logic [LANES-1:0][VALUE_W-1:0] lanes;
      logic                          playing;
      logic [KEY_IDX_W-1:0]          segment;
   } pose_type;

   string lane_names [LANES] = '{"pos_x", "pos_y", "pos_z", "angle"};

   longint      key_store [MAX_KEYFRAMES][LANES];
   longint      pose [LANES];
   longint      delta [LANES];
   bit          running;
   bit          latched;
   int unsigned seg_idx;
   int unsigned tick_cnt;
   int unsigned steps_cfg;
   int unsigned frames_cfg;
   pose_type    expected_poses [$];

   function automatic longint clamp_value(longint v);
      longint hi;
      longint lo;
      hi = (64'sd1 <<< (VALUE_W - 1)) - 64'sd1;
      lo = -hi - 64'sd1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   function automatic int unsigned steps_used();
      return (steps_cfg == 0) ? 1 : steps_cfg;
   endfunction

   function automatic int unsigned frames_used();
      return (frames_cfg > MAX_KEYFRAMES) ? MAX_KEYFRAMES : frames_cfg;
   endfunction

   function automatic void load_segment_deltas();
      longint diff;
      for (int k = 0; k < LANES; k++) begin
         if (seg_idx + 1 >= MAX_KEYFRAMES) begin
            delta[k] = 0;
         end else begin
            diff = key_store[seg_idx + 1][k] - key_store[seg_idx][k];
            delta[k] = clamp_value(diff / longint'(steps_used()));
         end
      end
   endfunction

   function automatic void advance_frame();
      if (running) begin
         if (tick_cnt >= steps_used()) begin
            seg_idx++;
            if (int'(seg_idx) > int'(frames_used()) - 2) begin
               seg_idx = 0;
               running = 1'b0;
            end else begin
               tick_cnt = 0;
               load_segment_deltas();
            end
         end else begin
            for (int k = 0; k < LANES; k++) pose[k] = clamp_value(pose[k] + delta[k]);
            tick_cnt = (tick_cnt + 1) & 32'hFFF;
         end
      end
   endfunction

   function automatic pose_type advance_player();
      pose_type result;
      if (req_operation == OP_WRITE) begin
         key_store[req_key_index][0] = clamp_value(longint'($signed(req_key_x)));
         key_store[req_key_index][1] = clamp_value(longint'($signed(req_key_y)));
         key_store[req_key_index][2] = clamp_value(longint'($signed(req_key_z)));
         key_store[req_key_index][3] = clamp_value(longint'($signed(req_key_angle)));
      end else begin
         if (req_start_pressed && !latched) begin
            if (!running && frames_used() > 1) begin
               for (int k = 0; k < LANES; k++) pose[k] = key_store[0][k];
               seg_idx = 0;
               load_segment_deltas();
               running  = 1'b1;
               tick_cnt = 0;
               latched  = 1'b1;
            end else begin
               running = 1'b0;
            end
         end
         if (req_rearm_pressed) latched = 1'b0;
         advance_frame();
      end
      for (int k = 0; k < LANES; k++) result.lanes[k] = pose[k][VALUE_W-1:0];
      result.playing = running;
      result.segment = seg_idx[KEY_IDX_W-1:0];
      return result;
   endfunction

   task automatic compare_field(input string name, input logic [VALUE_W-1:0] want,
                                input logic [VALUE_W-1:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      pose_type want;
      pose_type got;
      if (reset) begin
         for (int i = 0; i < MAX_KEYFRAMES; i++)
            for (int k = 0; k < LANES; k++) key_store[i][k] = 0;
         for (int k = 0; k < LANES; k++) begin
            pose[k]  = 0;
            delta[k] = 0;
         end
         running       = 1'b0;
         latched       = 1'b0;
         seg_idx       = 0;
         tick_cnt      = STEP_RESET;
         steps_cfg     = STEPS_RESET;
         frames_cfg    = FRAMES_RESET;
         fail_count    = 0;
         checked_count = 0;
         expected_poses.delete();
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_STEPS) steps_cfg = csr_data & 12'hFFF;
            else if (csr_index == CSR_FRAMES) frames_cfg = csr_data & 12'h07F;
         end
         if (req_valid && !req_stall)
            expected_poses.insert(expected_poses.size(), advance_player());
         if (rsp_valid && !rsp_stall) begin
            got.lanes   = {rsp_angle, rsp_pos_z, rsp_pos_y, rsp_pos_x};
            got.playing = rsp_playing;
            got.segment = rsp_segment;
            if (expected_poses.size() == 0) begin
               fail_count++;
               $display("%0t: result with none expected, expected nothing, got %h",
                        $time, got);
            end else begin
               want = expected_poses.pop_front();
               for (int k = 0; k < LANES; k++)
                  compare_field(lane_names[k], want.lanes[k], got.lanes[k]);
               compare_field("playing", VALUE_W'(want.playing), VALUE_W'(got.playing));
               compare_field("segment", VALUE_W'(want.segment), VALUE_W'(got.segment));
               checked_count++;
            end
         end
      end
      pending <= expected_poses.size();
   end

endmodule

// ===== dv/tb.sv =====
// testbench top for keyframe_linear_interpolator_core: clock, reset, keyframe and tick
// stimulus, register settings, result-side stalls and the verdict
// depends on kli_pkg, keyframe_linear_interpolator_core and kli_checker
module tb;
   import kli_pkg::*;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int HOLD_AT       = 150;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_ITEMS   = 100;
   localparam int PHASES        = 10;
   localparam logic [VALUE_W-1:0] MAXV = 32'h7FFF_FFFF;
   localparam logic [VALUE_W-1:0] MINV = 32'h8000_0000;

   logic                  clock             = 1'b0;
   logic                  reset             = 1'b1;
   logic                  req_valid         = 1'b0;
   logic                  req_stall;
   logic                  req_operation     = OP_WRITE;
   logic [KEY_IDX_W-1:0]  req_key_index     = '0;
   logic [VALUE_W-1:0]    req_key_x         = '0;
   logic [VALUE_W-1:0]    req_key_y         = '0;
   logic [VALUE_W-1:0]    req_key_z         = '0;
   logic [VALUE_W-1:0]    req_key_angle     = '0;
   logic                  req_start_pressed = 1'b0;
   logic                  req_rearm_pressed = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall         = 1'b0;
   logic [VALUE_W-1:0]    rsp_pos_x;
   logic [VALUE_W-1:0]    rsp_pos_y;
   logic [VALUE_W-1:0]    rsp_pos_z;
   logic [VALUE_W-1:0]    rsp_angle;
   logic                  rsp_playing;
   logic [KEY_IDX_W-1:0]  rsp_segment;
   logic                  csr_write         = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index         = CSR_STEPS;
   logic [CSR_DATA_W-1:0] csr_data          = '0;

   int fail_count;
   int pending;
   int checked_count;
   int send_idle_pct = 11;
   int recv_idle_pct = 67;
   int n_sent        = 0;
   int n_settings    = 1;
   int cur_frames    = FRAMES_RESET;
   int hold_left     = 0;
   bit hold_done     = 1'b0;
   int cycle_count   = 0;

   int unsigned steps_plan  [PHASES] = '{0, 1, 3, 4095, 2, 1, 7, 4, 0, 0};
   int unsigned frames_plan [PHASES] = '{2, 64, 5, 127, 0, 1, 65, 12, 0, 0};

   keyframe_linear_interpolator_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_key_index     (req_key_index),
      .req_key_x         (req_key_x),
      .req_key_y         (req_key_y),
      .req_key_z         (req_key_z),
      .req_key_angle     (req_key_angle),
      .req_start_pressed (req_start_pressed),
      .req_rearm_pressed (req_rearm_pressed),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pos_x         (rsp_pos_x),
      .rsp_pos_y         (rsp_pos_y),
      .rsp_pos_z         (rsp_pos_z),
      .rsp_angle         (rsp_angle),
      .rsp_playing       (rsp_playing),
      .rsp_segment       (rsp_segment),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   kli_checker u_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_key_index     (req_key_index),
      .req_key_x         (req_key_x),
      .req_key_y         (req_key_y),
      .req_key_z         (req_key_z),
      .req_key_angle     (req_key_angle),
      .req_start_pressed (req_start_pressed),
      .req_rearm_pressed (req_rearm_pressed),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pos_x         (rsp_pos_x),
      .rsp_pos_y         (rsp_pos_y),
      .rsp_pos_z         (rsp_pos_z),
      .rsp_angle         (rsp_angle),
      .rsp_playing       (rsp_playing),
      .rsp_segment       (rsp_segment),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .fail_count        (fail_count),
      .pending           (pending),
      .checked_count     (checked_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still expected", cycle_count, pending);
         $display("** keyframe_linear_interpolator_core: FAILED **");
         $finish;
      end
   end

   // result side: random stalls plus one long hold-off that backs up the block
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && n_sent >= HOLD_AT) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   function automatic logic [VALUE_W-1:0] pick_value();
      int frac;
      frac = int'($urandom_range(0, 511)) - 256;
      case ($urandom_range(7))
         0:       return MAXV;
         1:       return MINV;
         2:       return '0;
         3, 4:    return VALUE_W'(frac * 65536 + int'($urandom_range(0, 65535)));
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [KEY_IDX_W-1:0] pick_slot();
      int lim;
      lim = (cur_frames > MAX_KEYFRAMES) ? MAX_KEYFRAMES : cur_frames;
      if (lim < 2) lim = 2;
      if ($urandom_range(9) == 0) return KEY_IDX_W'($urandom());
      return KEY_IDX_W'($urandom_range(0, lim - 1));
   endfunction

   // one transfer on the request side, with an optional gap before it
   task automatic offer(input logic op, input logic [KEY_IDX_W-1:0] idx,
                        input logic [VALUE_W-1:0] kx, input logic [VALUE_W-1:0] ky,
                        input logic [VALUE_W-1:0] kz, input logic [VALUE_W-1:0] ka,
                        input logic st, input logic rm);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_key_index     <= idx;
      req_key_x         <= kx;
      req_key_y         <= ky;
      req_key_z         <= kz;
      req_key_angle     <= ka;
      req_start_pressed <= st;
      req_rearm_pressed <= rm;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      n_sent++;
   endtask

   task automatic send_write(input logic [KEY_IDX_W-1:0] idx, input logic [VALUE_W-1:0] kx,
                             input logic [VALUE_W-1:0] ky, input logic [VALUE_W-1:0] kz,
                             input logic [VALUE_W-1:0] ka);
      offer(OP_WRITE, idx, kx, ky, kz, ka, 1'($urandom()), 1'($urandom()));
   endtask

   task automatic send_tick(input logic st, input logic rm);
      offer(OP_TICK, KEY_IDX_W'($urandom()), $urandom(), $urandom(), $urandom(), $urandom(),
            st, rm);
   endtask

   task automatic send_random_key();
      send_write(pick_slot(), pick_value(), pick_value(), pick_value(), pick_value());
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_config(input int unsigned steps, input int unsigned frames);
      csr_write <= 1'b1;
      csr_index <= CSR_STEPS;
      csr_data  <= CSR_DATA_W'(steps);
      @(posedge clock);
      csr_index <= CSR_FRAMES;
      csr_data  <= CSR_DATA_W'(($urandom_range(0, 31) << FRAMES_W) | frames);
      @(posedge clock);
      csr_write <= 1'b0;
      cur_frames = frames;
      n_settings++;
   endtask

   // mostly load keys, rearm, start and let it play; now and then a stray item
   task automatic play_scene();
      int run_len;
      if ($urandom_range(9) == 0) begin
         offer(1'($urandom()), KEY_IDX_W'($urandom()), pick_value(), pick_value(),
               pick_value(), pick_value(), 1'($urandom()), 1'($urandom()));
      end else begin
         repeat ($urandom_range(0, 3)) send_random_key();
         send_tick(1'b0, 1'b1);
         send_tick(1'b1, 1'b0);
         run_len = $urandom_range(1, 40);
         for (int k = 0; k < run_len; k++) begin
            if ($urandom_range(19) == 0) send_random_key();
            else send_tick($urandom_range(99) < 3, $urandom_range(99) < 5);
         end
      end
   endtask

   initial begin
      int phase_end;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // register defaults: start, ignored start, stop by start after rearm
      send_write(0, MAXV, MAXV, MAXV, MAXV);
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b0);
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b1);
      send_tick(1'b1, 1'b0);
      send_tick(1'b1, 1'b1);
      settle();

      // one tick per segment: saturated increments, saturated sum, end of playback
      write_config(1, 3);
      send_write(0, MAXV, MAXV, MAXV, MAXV);
      send_write(1, MINV, MINV, MINV, MINV);
      send_write(2, '0, '0, '0, '0);
      send_write(63, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001);
      send_tick(1'b0, 1'b1);
      send_tick(1'b1, 1'b0);
      send_write(1, MAXV, MAXV, MAXV, MAXV);
      send_write(2, MINV, MINV, MINV, MINV);
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b0);
      send_tick(1'b1, 1'b0);
      send_tick(1'b1, 1'b1);
      send_tick(1'b1, 1'b0);

      for (int p = 0; p < PHASES; p++) begin
         settle();
         if (p < 4) begin
            send_idle_pct = 11;
            recv_idle_pct = 67;
         end else if (p < 7) begin
            send_idle_pct = 67;
            recv_idle_pct = 11;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (p >= 8) write_config($urandom_range(1, 9), $urandom_range(2, 20));
         else write_config(steps_plan[p], frames_plan[p]);
         phase_end = n_sent + PHASE_ITEMS;
         while (n_sent < phase_end) play_scene();
      end
      settle();

      $display("covered %0d items under %0d register settings, %0d results compared",
               n_sent, n_settings, checked_count);
      if (fail_count == 0 && pending == 0) begin
         $display("** keyframe_linear_interpolator_core: PASSED **");
      end else begin
         $display("** keyframe_linear_interpolator_core: FAILED **");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/kli_pkg.sv
hdl/kli_div.sv
hdl/kli_datapath.sv
hdl/kli_ctrl.sv
hdl/keyframe_linear_interpolator_core.sv
dv/kli_checker.sv
dv/tb.sv
